>>> design/ngep_pkg.sv
// Shared types and codes for the node group edge policy block.
package ngep_pkg;

	localparam int KEY_W = 64;
	localparam int GRP_W = 3;
	localparam int CMD_W = 2;
	localparam int STS_W = 2;
	localparam int MAT_W = 64;

	localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_GET  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EDGE = 2'd2;

	localparam logic [STS_W-1:0] STS_OK   = 2'd0;
	localparam logic [STS_W-1:0] STS_MISS = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL = 2'd2;

	localparam logic REG_ALLOW = 1'b0;
	localparam logic REG_DENY  = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [KEY_W-1:0] key_a;
		logic [KEY_W-1:0] key_b;
		logic [GRP_W-1:0] group_in;
	} in_word_t;

	typedef struct packed {
		logic [STS_W-1:0] status;
		logic [GRP_W-1:0] group_out;
		logic             edge_allowed;
	} out_word_t;

	// Word travelling down the row of cells; hit_a doubles as "placed" for a set.
	typedef struct packed {
		logic             vld;
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] key_a;
		logic [KEY_W-1:0] key_b;
		logic [GRP_W-1:0] grp;
		logic             hit_a;
		logic [GRP_W-1:0] grp_a;
		logic             hit_b;
		logic [GRP_W-1:0] grp_b;
	} chain_t;

endpackage

>>> design/ngep_cell.sv
// One table entry: compares the passing word against its key and updates itself on a set.
module ngep_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  ngep_pkg::chain_t word_in,
	output ngep_pkg::chain_t word_out,
	output logic            occupied
);
	import ngep_pkg::*;

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [GRP_W-1:0] grp_q;
	chain_t           next_word;
	chain_t           word_s1;
	logic             set_cmd;
	logic             hit_a;
	logic             hit_b;
	logic             claim;

	always_comb begin
		set_cmd   = word_in.vld && (word_in.cmd == CMD_SET);
		hit_a     = valid_q && (key_q == word_in.key_a);
		hit_b     = valid_q && (key_q == word_in.key_b);
		// Entries fill from the bottom, so the first free cell lies past any match.
		claim     = set_cmd && !valid_q && !word_in.hit_a;
		next_word = word_in;
		if (hit_a) begin
			next_word.hit_a = 1'b1;
			next_word.grp_a = grp_q;
		end
		if (claim) begin
			next_word.hit_a = 1'b1;
		end
		if (hit_b) begin
			next_word.hit_b = 1'b1;
			next_word.grp_b = grp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (claim) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			key_q <= word_in.key_a;
		end
		if (claim || (set_cmd && hit_a)) begin
			grp_q <= word_in.grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_s1 <= '0;
		end else begin
			word_s1 <= next_word;
		end
	end

	assign word_out = word_s1;
	assign occupied = valid_q;

endmodule

>>> design/ngep_pol.sv
// End of the row: turns the collected lookups into status, group and edge verdict.
module ngep_pol (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ngep_pkg::chain_t                 word_in,
	input  logic [ngep_pkg::MAT_W-1:0]       allow_matrix,
	input  logic [ngep_pkg::MAT_W-1:0]       deny_matrix,
	output logic                             result_valid,
	output ngep_pkg::out_word_t              result
);
	import ngep_pkg::*;

	out_word_t                        res_d;
	logic [2*GRP_W-1:0]               bit_sel;
	out_word_t                        res_q;
	logic                             vld_q;

	always_comb begin
		res_d   = '0;
		bit_sel = {word_in.grp_a, word_in.grp_b};
		unique case (word_in.cmd)
			CMD_SET: begin
				res_d.status = word_in.hit_a ? STS_OK : STS_FULL;
			end
			CMD_GET: begin
				res_d.status    = word_in.hit_a ? STS_OK : STS_MISS;
				res_d.group_out = word_in.hit_a ? word_in.grp_a : '0;
			end
			CMD_EDGE: begin
				// A non-empty allow list overrides the deny list.
				res_d.edge_allowed = (allow_matrix != '0) ? allow_matrix[bit_sel]
				                                          : !deny_matrix[bit_sel];
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= word_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign result_valid = vld_q;
	assign result       = res_q;

endmodule

>>> design/node_group_edge_policy_unit.sv
// Node group table with edge policy check, built as a row of entry cells.
// Each command is registered at the entry stage, then in every entry cell in turn, then in the policy stage.
// Throughput: one command per cycle; each word steps through one entry cell a cycle.
// Reset clears all entry valid bits, the row and both matrix registers.
// busy never rises; results cannot be held off by the receiver.
module node_group_edge_policy_unit #(
	parameter int NODES  = 64,
	parameter int GROUPS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [3:0]                   paddr,
	input  logic [ngep_pkg::MAT_W-1:0]   pwdata,
	output logic [ngep_pkg::MAT_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  ngep_pkg::in_word_t           item,
	output logic                         result_valid,
	output ngep_pkg::out_word_t          result
);
	import ngep_pkg::*;

	logic [MAT_W-1:0] allow_q;
	logic [MAT_W-1:0] deny_q;
	logic             cfg_wr;
	logic             accept;
	logic [GRP_W-1:0] grp_sat;
	chain_t           entry_s1;
	chain_t           chain [NODES+1];
	logic [NODES-1:0] occ;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign accept = start && !busy;
	assign prdata = (paddr[3] == REG_DENY) ? deny_q : allow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q <= '0;
			deny_q  <= '0;
		end else if (cfg_wr) begin
			if (paddr[3] == REG_ALLOW) begin
				allow_q <= pwdata;
			end else begin
				deny_q <= pwdata;
			end
		end
	end

	// Saturate an out-of-range group to the top group.
	assign grp_sat = (int'(item.group_in) >= GROUPS) ? GRP_W'(GROUPS - 1) : item.group_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_s1 <= '0;
		end else begin
			entry_s1.vld   <= accept;
			entry_s1.cmd   <= item.command;
			entry_s1.key_a <= item.key_a;
			entry_s1.key_b <= item.key_b;
			entry_s1.grp   <= grp_sat;
			entry_s1.hit_a <= 1'b0;
			entry_s1.grp_a <= '0;
			entry_s1.hit_b <= 1'b0;
			entry_s1.grp_b <= '0;
		end
	end

	assign chain[0] = entry_s1;

	for (genvar i = 0; i < NODES; i++) begin : g_cell
		ngep_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.word_in  (chain[i]),
			.word_out (chain[i+1]),
			.occupied (occ[i])
		);
	end

	ngep_pol u_pol (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_in      (chain[NODES]),
		.allow_matrix (allow_q),
		.deny_matrix  (deny_q),
		.result_valid (result_valid),
		.result       (result)
	);

	// Occupied entries always form a block starting at entry zero.
	a_occ_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(occ & (occ + NODES'(1))) == '0)
		else $error("occupied entries are not contiguous");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == STS_FULL) |-> (&occ))
		else $error("table full reported with a free entry");

	a_edge_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.edge_allowed |-> (result.status == STS_OK) &&
		(result.group_out == '0))
		else $error("edge verdict with non-ok status or group");

endmodule
